FILE: rtl/tmt_pkg.sv
`timescale 1ns / 1ps

package tmt_pkg;

  localparam int HOLD_SCALE = 1000;
  localparam int HOLD_RESET = 5;
  localparam int HOLD_W = 8;
  localparam int LIMIT_W = 18;
  localparam int MSG_W = 16;
  localparam int TIME_W = 32;
  localparam int CNT_OUT_W = 4;

  localparam logic ACT_POST = 1'b0;
  localparam logic ACT_SWEEP = 1'b1;

  typedef enum logic [1:0] {
    ST_NEW = 2'd0,
    ST_REFRESH = 2'd1,
    ST_DROP = 2'd2,
    ST_SWEEP = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    CS_IDLE,
    CS_SCAN,
    CS_FINISH,
    CS_OUT
  } ctrl_state_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic trim;
  } mem_cmd_t;

  typedef struct packed {
    status_t status;
    logic [CNT_OUT_W-1:0] active;
    logic sweep;
    logic [MSG_W-1:0] head;
    logic [CNT_OUT_W-1:0] expired;
  } result_t;

endpackage

FILE: rtl/tmt_store.sv
`timescale 1ns / 1ps

module tmt_store
  import tmt_pkg::*;
#(
  parameter int SLOTS = 10,
  parameter int IDX_W = 4,
  parameter int CNT_W = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  mem_cmd_t          cmd,
  input  logic [IDX_W-1:0]  rd_addr,
  input  logic [IDX_W-1:0]  wr_addr,
  input  logic [MSG_W-1:0]  wr_msg,
  input  logic [TIME_W-1:0] wr_time,
  input  logic [CNT_W-1:0]  trim_count,
  output logic [MSG_W-1:0]  rd_msg,
  output logic [TIME_W-1:0] rd_time
);

  logic [MSG_W-1:0]  msg_mem [SLOTS];
  logic [TIME_W-1:0] time_mem [SLOTS];
  logic [SLOTS-1:0]  valid;
  logic [MSG_W-1:0]  msg_q;
  logic [TIME_W-1:0] time_q;
  logic              valid_q;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      msg_mem[wr_addr] <= wr_msg;
      time_mem[wr_addr] <= wr_time;
    end
    if (cmd.rd) begin
      msg_q <= msg_mem[rd_addr];
      time_q <= time_mem[rd_addr];
      valid_q <= valid[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (cmd.trim) begin
      for (int j = 0; j < SLOTS; j++) begin
        valid[j] <= valid[j] && (CNT_W'(j) < trim_count);
      end
    end else if (cmd.wr) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  assign rd_msg = valid_q ? msg_q : '0;
  assign rd_time = valid_q ? time_q : '0;

endmodule

FILE: rtl/tmt_ctrl.sv
`timescale 1ns / 1ps

module tmt_ctrl
  import tmt_pkg::*;
#(
  parameter int SLOTS = 10,
  parameter int IDX_W = 4,
  parameter int CNT_W = 4
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [MSG_W+TIME_W-1:0] s_tdata,
  input  logic                  s_tuser,
  input  logic                  cfg_valid,
  input  logic [HOLD_W-1:0]     cfg_data,
  output mem_cmd_t              cmd,
  output logic [IDX_W-1:0]      rd_addr,
  output logic [IDX_W-1:0]      wr_addr,
  output logic [MSG_W-1:0]      wr_msg,
  output logic [TIME_W-1:0]     wr_time,
  output logic [CNT_W-1:0]      trim_count,
  input  logic [MSG_W-1:0]      rd_msg,
  input  logic [TIME_W-1:0]     rd_time,
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res
);

  localparam logic [IDX_W-1:0] LAST = IDX_W'(SLOTS - 1);

  ctrl_state_t state, state_next;

  logic [LIMIT_W-1:0] limit;
  logic               sweep_on;
  logic               is_sweep;
  logic [MSG_W-1:0]   id;
  logic [TIME_W-1:0]  now;
  logic [IDX_W-1:0]   cur;
  logic [CNT_W-1:0]   cnt;
  logic [CNT_W-1:0]   keep;
  logic [CNT_W-1:0]   exp_cnt;
  logic               match;
  logic [IDX_W-1:0]   match_idx;
  logic               empty;
  logic [IDX_W-1:0]   empty_idx;
  logic [MSG_W-1:0]   head;
  logic               slot0_empty;

  logic               occupied;
  logic               expired;
  logic               kept;
  logic               store_new;
  logic [CNT_W-1:0]   post_count;
  logic [CNT_W+CNT_OUT_W-1:0] active_wide;
  logic [CNT_W+CNT_OUT_W-1:0] expired_wide;

  assign occupied = rd_msg != '0;
  assign expired = (now - rd_time) > TIME_W'(limit);
  assign kept = occupied && !expired;
  assign store_new = (id != '0) && !match && empty;
  assign post_count = store_new ? cnt + 1'b1 : cnt;
  assign active_wide = {{CNT_OUT_W{1'b0}}, is_sweep ? keep : post_count};
  assign expired_wide = {{CNT_OUT_W{1'b0}}, exp_cnt};

  always_comb begin
    state_next = state;
    case (state)
      CS_IDLE: begin
        if (s_tvalid) begin
          state_next = CS_SCAN;
        end
      end
      CS_SCAN: begin
        if (cur == LAST) begin
          state_next = CS_FINISH;
        end
      end
      CS_FINISH: state_next = CS_OUT;
      CS_OUT: begin
        if (res_ready) begin
          state_next = CS_IDLE;
        end
      end
      default: state_next = CS_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    res_valid = 1'b0;
    cmd = '0;
    rd_addr = '0;
    wr_addr = keep[IDX_W-1:0];
    wr_msg = rd_msg;
    wr_time = rd_time;
    trim_count = keep;
    case (state)
      CS_IDLE: begin
        s_tready = 1'b1;
        cmd.rd = s_tvalid;
      end
      CS_SCAN: begin
        cmd.rd = cur != LAST;
        rd_addr = cur + 1'b1;
        cmd.wr = is_sweep && kept;
      end
      CS_FINISH: begin
        if (is_sweep) begin
          cmd.trim = 1'b1;
        end else begin
          cmd.wr = (id != '0) && (match || empty);
          wr_addr = match ? match_idx : empty_idx;
          wr_msg = id;
          wr_time = now;
        end
      end
      CS_OUT: res_valid = 1'b1;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= CS_IDLE;
      sweep_on <= 1'b0;
      limit <= LIMIT_W'(HOLD_RESET * HOLD_SCALE);
    end else begin
      state <= state_next;
      if (cfg_valid) begin
        limit <= LIMIT_W'(cfg_data * HOLD_SCALE);
      end
      if (state == CS_FINISH) begin
        if (is_sweep) begin
          if (keep == '0) begin
            sweep_on <= 1'b0;
          end
        end else if (id != '0 && slot0_empty) begin
          sweep_on <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      CS_IDLE: begin
        is_sweep <= s_tuser == ACT_SWEEP;
        id <= s_tdata[MSG_W-1:0];
        now <= s_tdata[MSG_W+TIME_W-1:MSG_W];
        cur <= '0;
        cnt <= '0;
        keep <= '0;
        exp_cnt <= '0;
        match <= 1'b0;
        empty <= 1'b0;
        head <= '0;
        slot0_empty <= 1'b0;
      end
      CS_SCAN: begin
        if (cur != LAST) begin
          cur <= cur + 1'b1;
        end
        if (is_sweep) begin
          if (occupied && expired) begin
            exp_cnt <= exp_cnt + 1'b1;
          end
          if (kept) begin
            keep <= keep + 1'b1;
            if (keep == '0) begin
              head <= rd_msg;
            end
          end
        end else begin
          if (cur == '0) begin
            head <= rd_msg;
            slot0_empty <= !occupied;
          end
          if (occupied) begin
            cnt <= cnt + 1'b1;
          end
          if (!match && occupied && rd_msg == id) begin
            match <= 1'b1;
            match_idx <= cur;
          end
          if (!empty && !occupied) begin
            empty <= 1'b1;
            empty_idx <= cur;
          end
        end
      end
      CS_FINISH: begin
        res.active <= active_wide[CNT_OUT_W-1:0];
        if (is_sweep) begin
          res.status <= ST_SWEEP;
          res.sweep <= sweep_on && (keep != '0);
          res.head <= head;
          res.expired <= expired_wide[CNT_OUT_W-1:0];
        end else begin
          if (id == '0) begin
            res.status <= ST_DROP;
          end else if (match) begin
            res.status <= ST_REFRESH;
          end else if (empty) begin
            res.status <= ST_NEW;
          end else begin
            res.status <= ST_DROP;
          end
          res.sweep <= sweep_on || (id != '0 && slot0_empty);
          res.head <= (store_new && empty_idx == '0) ? id : head;
          res.expired <= '0;
        end
      end
      default: ;
    endcase
  end

endmodule

FILE: rtl/timed_message_table_unit.sv
`timescale 1ns / 1ps

// Table of active messages with ageing.
// Input transfers on the s_ group: s_tuser selects a post (0) or an expiry
// sweep (1); s_tdata carries the message identifier and the millisecond time.
// Each input transfer yields exactly one result transfer on the m_ group:
// m_tuser holds the status and m_tdata the occupied slot count, the sweep
// enable flag, the identifier in slot 0 and the number of expired slots.
// The hold time in seconds is to be written through cfg_valid/cfg_data only
// while the block is idle; the block itself does not enforce this.
// The result is offered on m_tvalid after the scan state reads the slot memory
// one entry per cycle (a sweep writes kept entries back to the front), the
// finish state writes the posted message or trims the table, and the out
// state hands the result to the output register. A new item is accepted only
// once the previous result has moved into the output register.
// When the receiver stalls, the result waits in the output register; a
// following item is processed and then held until the register frees.
// Reset empties the table at once, clears the sweep flag and sets the hold
// time to five seconds.

module timed_message_table_unit
  import tmt_pkg::*;
#(
  parameter int SLOTS = 10
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // message_id[15:0], now_ms[47:16]
  input  logic        s_tuser,  // action[0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,  // active_count[3:0], sweep_enabled[4],
                                // head_message[20:5], expired_count[24:21]
  output logic [1:0]  m_tuser,  // post_status[1:0]
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_data
);

  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  mem_cmd_t          cmd;
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  wr_addr;
  logic [MSG_W-1:0]  wr_msg;
  logic [TIME_W-1:0] wr_time;
  logic [CNT_W-1:0]  trim_count;
  logic [MSG_W-1:0]  rd_msg;
  logic [TIME_W-1:0] rd_time;
  logic              res_valid;
  logic              res_ready;
  result_t           res;
  result_t           out_q;

  assign cfg_ready = 1'b1;
  assign res_ready = !m_tvalid || m_tready;

  tmt_ctrl #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_ctrl (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .cfg_valid(cfg_valid),
    .cfg_data(cfg_data),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_msg(wr_msg),
    .wr_time(wr_time),
    .trim_count(trim_count),
    .rd_msg(rd_msg),
    .rd_time(rd_time),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res(res)
  );

  tmt_store #(
    .SLOTS(SLOTS),
    .IDX_W(IDX_W),
    .CNT_W(CNT_W)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .cmd(cmd),
    .rd_addr(rd_addr),
    .wr_addr(wr_addr),
    .wr_msg(wr_msg),
    .wr_time(wr_time),
    .trim_count(trim_count),
    .rd_msg(rd_msg),
    .rd_time(rd_time)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      out_q <= res;
    end
  end

  assign m_tuser = out_q.status;
  assign m_tdata = {7'b0, out_q.expired, out_q.head, out_q.sweep, out_q.active};

  a_accept_then_busy : assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !res_valid && !s_tready)
    else $error("result offered right after an input transfer");

  a_post_no_expiry : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status != ST_SWEEP) |-> res.expired == '0)
    else $error("post reports expired slots");

  a_new_has_head : assert property (@(posedge clk) disable iff (rst)
    (res_valid && res.status == ST_NEW) |-> (res.head != '0 && res.sweep))
    else $error("stored message leaves slot 0 empty or sweeps disabled");

endmodule
